// File: hw/rtl/u8u16_pkg.sv
// ----------------------------------------------------------------------------
// u8u16_pkg: shared types, constants and decode helpers
// Lead byte classification, code point assembly and surrogate splitting
// for the UTF-8 to UTF-16 transcoder.
// ----------------------------------------------------------------------------
`default_nettype none

package u8u16_pkg;

  localparam int unsigned MaxUnits = 3;

  localparam logic [15:0] ReplUnit   = 16'h0023;  // '#'
  localparam logic [20:0] SuppBase   = 21'h10000;
  localparam logic [15:0] HiSurrBase = 16'hD800;
  localparam logic [5:0]  LoSurrTag  = 6'b110111;  // 0xDC00 >> 10

  localparam logic [7:0] Mask1 = 8'h7f;
  localparam logic [7:0] Mask2 = 8'h1f;
  localparam logic [7:0] Mask3 = 8'h0f;
  localparam logic [7:0] Mask4 = 8'h07;
  localparam logic [7:0] MaskC = 8'h3f;

  // Units caused by one input byte, first unit in units[0].
  typedef struct packed {
    logic [1:0]            count;
    logic [2:0][15:0]      units;
  } u8u16_res_t;

  // Sequence length from the top five bits; zero means invalid lead.
  function automatic logic [2:0] seq_len(input logic [7:0] b);
    logic [2:0] len;
    len = 3'd0;
    if (b[7] == 1'b0) begin
      len = 3'd1;
    end else if (b[7:5] == 3'b110) begin
      len = 3'd2;
    end else if (b[7:4] == 4'b1110) begin
      len = 3'd3;
    end else if (b[7:3] == 5'b11110) begin
      len = 3'd4;
    end
    return len;
  endfunction

  // A lone byte: its value if it is a one-byte sequence, else '#'.
  function automatic logic [15:0] single_unit(input logic [7:0] b);
    return (seq_len(b) == 3'd1) ? {8'h00, b & Mask1} : ReplUnit;
  endfunction

  // Two-byte code point, always below 0x800.
  function automatic logic [15:0] cp2(input logic [7:0] b0, input logic [7:0] b1);
    logic [7:0] m0;
    logic [7:0] m1;
    m0 = b0 & Mask2;
    m1 = b1 & MaskC;
    return {5'b0, m0[4:0], m1[5:0]};
  endfunction

  // Full code point of a sequence of length len (1 to 4).
  function automatic logic [20:0] assemble_cp(input logic [2:0] len,
                                              input logic [7:0] b0,
                                              input logic [7:0] b1,
                                              input logic [7:0] b2,
                                              input logic [7:0] b3);
    logic [20:0] cp;
    logic [7:0]  m0;
    logic [7:0]  m1;
    logic [7:0]  m2;
    logic [7:0]  m3;
    m1 = b1 & MaskC;
    m2 = b2 & MaskC;
    m3 = b3 & MaskC;
    unique case (len)
      3'd2: begin
        m0 = b0 & Mask2;
        cp = {10'b0, m0[4:0], m1[5:0]};
      end
      3'd3: begin
        m0 = b0 & Mask3;
        cp = {5'b0, m0[3:0], m1[5:0], m2[5:0]};
      end
      3'd4: begin
        m0 = b0 & Mask4;
        cp = {m0[2:0], m1[5:0], m2[5:0], m3[5:0]};
      end
      default: begin
        m0 = b0 & Mask1;
        cp = {13'b0, m0};
      end
    endcase
    return cp;
  endfunction

endpackage : u8u16_pkg

`default_nettype wire

// File: hw/rtl/u8u16_decoder.sv
// ----------------------------------------------------------------------------
// u8u16_decoder: sequence gathering and code unit decode
// Holds a partial UTF-8 sequence and turns each accepted byte into zero to
// three UTF-16 code units in a single combinational pass.
// ----------------------------------------------------------------------------
`default_nettype none

module u8u16_decoder
  import u8u16_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_fire_i,
  input  wire logic [7:0] in_byte_i,
  input  wire logic       final_byte_i,
  output u8u16_res_t      res_o
);

  logic [2:0][7:0] held_q;
  logic [1:0]      held_cnt_q;
  logic [2:0]      exp_len_q;

  logic [7:0]  buf0, buf1, buf2;
  logic [2:0]  count;
  logic [2:0]  lead_len;
  logic        decode_now;
  logic [20:0] cp;
  logic [20:0] off;
  logic [15:0] hi_unit;
  logic [1:0]  rest_cnt;
  u8u16_res_t  res;

  // Byte string as seen by this step: held bytes, then the new byte.
  assign buf0     = (held_cnt_q > 2'd0) ? held_q[0] : in_byte_i;
  assign buf1     = (held_cnt_q > 2'd1) ? held_q[1] : in_byte_i;
  assign buf2     = (held_cnt_q > 2'd2) ? held_q[2] : in_byte_i;
  assign count    = {1'b0, held_cnt_q} + 3'd1;
  assign rest_cnt = held_cnt_q;
  assign lead_len = seq_len(buf0);

  assign decode_now = final_byte_i
                    || ((held_cnt_q == 2'd0) && (lead_len <= 3'd1))
                    || ((held_cnt_q != 2'd0) && (count >= exp_len_q));

  assign cp      = assemble_cp(lead_len, buf0, buf1, buf2, in_byte_i);
  assign off     = cp - SuppBase;
  assign hi_unit = HiSurrBase + {5'b0, off[20:10]};

  always_comb begin
    res = '0;
    if (decode_now) begin
      if ((lead_len != 3'd0) && (lead_len <= count)) begin
        // Complete sequence: one unit or a surrogate pair.
        if (cp >= SuppBase) begin
          res.count    = 2'd2;
          res.units[0] = hi_unit;
          res.units[1] = {LoSurrTag, cp[9:0]};
        end else begin
          res.count    = 2'd1;
          res.units[0] = cp[15:0];
        end
      end else begin
        // Bad or cut-short lead: replace it, then decode what follows.
        res.units[0] = ReplUnit;
        if (rest_cnt == 2'd0) begin
          res.count = 2'd1;
        end else if ((rest_cnt == 2'd2) && (seq_len(buf1) == 3'd2)) begin
          res.count    = 2'd2;
          res.units[1] = cp2(buf1, buf2);
        end else if (rest_cnt == 2'd2) begin
          res.count    = 2'd3;
          res.units[1] = single_unit(buf1);
          res.units[2] = single_unit(buf2);
        end else begin
          res.count    = 2'd2;
          res.units[1] = single_unit(buf1);
        end
      end
    end
  end

  assign res_o = res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_cnt_q <= 2'd0;
      exp_len_q  <= 3'd0;
    end else if (in_fire_i) begin
      if (decode_now) begin
        held_cnt_q <= 2'd0;
        exp_len_q  <= 3'd0;
      end else begin
        held_cnt_q <= held_cnt_q + 2'd1;
        if (held_cnt_q == 2'd0) begin
          exp_len_q <= lead_len;
        end
      end
    end
  end

  // Held bytes carry no reset; only entries below the count are read.
  always_ff @(posedge clk_i) begin
    if (in_fire_i && !decode_now) begin
      unique case (held_cnt_q)
        2'd0:    held_q[0] <= in_byte_i;
        2'd1:    held_q[1] <= in_byte_i;
        2'd2:    held_q[2] <= in_byte_i;
        default: held_q    <= held_q;
      endcase
    end
  end

endmodule : u8u16_decoder

`default_nettype wire

// File: hw/rtl/u8u16_outbuf.sv
// ----------------------------------------------------------------------------
// u8u16_outbuf: result register and unit drain
// Holds the units of one input byte and shifts them out one per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

module u8u16_outbuf
  import u8u16_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire u8u16_res_t  res_i,
  input  wire logic        load_i,
  output logic             can_load_o,
  output logic             valid_o,
  input  wire logic        ready_i,
  output logic [15:0]      unit_o,
  output logic             last_o
);

  logic [1:0]       cnt_q, cnt_d;
  logic [2:0][15:0] units_q, units_d;
  logic             pop;

  assign valid_o    = (cnt_q != 2'd0);
  assign pop        = valid_o && ready_i;
  // Take a new byte once the buffer drains this cycle.
  assign can_load_o = (cnt_q == 2'd0) || ((cnt_q == 2'd1) && ready_i);
  assign unit_o     = units_q[0];
  assign last_o     = (cnt_q == 2'd1);

  always_comb begin
    cnt_d   = cnt_q;
    units_d = units_q;
    if (load_i) begin
      cnt_d   = res_i.count;
      units_d = res_i.units;
    end else if (pop) begin
      cnt_d   = cnt_q - 2'd1;
      units_d = {16'h0000, units_q[2], units_q[1]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    units_q <= units_d;
  end

endmodule : u8u16_outbuf

`default_nettype wire

// File: hw/rtl/utf8_to_utf16_transcoder.sv
// ----------------------------------------------------------------------------
// utf8_to_utf16_transcoder: UTF-8 byte stream to UTF-16 unit stream
// Gathers UTF-8 sequences byte by byte and emits UTF-16 code units,
// surrogate pairs above the basic plane and '#' for bad or cut-short leads.
// ----------------------------------------------------------------------------
//
//  channel   direction  tdata                    tlast
//  s_axis    in         [7:0] in_byte            final_byte
//  m_axis    out        [15:0] utf16_unit        run_end
//
//  A byte that yields zero or one unit lets the next byte follow at once,
//  as long as the previous unit leaves in that same cycle.
//  A byte that yields more units (up to three) holds s_axis until its last
//  unit leaves: the result register drains one unit per transfer.
//  Reset clears the held count and the sequence length; no clearing pass.
//  A stall on m_axis holds the current unit and backs up into s_axis.
//
`default_nettype none

module utf8_to_utf16_transcoder
  import u8u16_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [7:0]  s_axis_tdata_i,   // [7:0] in_byte
  input  wire logic        s_axis_tlast_i,   // final_byte
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [15:0]      m_axis_tdata_o,   // [15:0] utf16_unit
  output logic             m_axis_tlast_o    // run_end
);

  logic       in_fire;
  logic       can_load;
  u8u16_res_t dec_res;

  // Accept a byte whenever the result register is free by the next edge.
  assign s_axis_tready_o = can_load;
  assign in_fire         = s_axis_tvalid_i && can_load;

  // Decode the byte against the held partial sequence.
  u8u16_decoder u_decoder (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_fire_i    (in_fire),
    .in_byte_i    (s_axis_tdata_i),
    .final_byte_i (s_axis_tlast_i),
    .res_o        (dec_res)
  );

  // Register the units and drain them one per transfer; the last unit of
  // each byte carries tlast.
  u8u16_outbuf u_outbuf (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .res_i      (dec_res),
    .load_i     (in_fire),
    .can_load_o (can_load),
    .valid_o    (m_axis_tvalid_o),
    .ready_i    (m_axis_tready_i),
    .unit_o     (m_axis_tdata_o),
    .last_o     (m_axis_tlast_o)
  );

endmodule : utf8_to_utf16_transcoder

`default_nettype wire

// File: hw/rtl/u8u16_checker.sv
// ----------------------------------------------------------------------------
// u8u16_checker: port-level checks for the transcoder
// Watches the stream ports and flags stalls, drain order and accept rules.
// ----------------------------------------------------------------------------
`default_nettype none

module u8u16_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tready_o,
  input wire logic        m_axis_tvalid_o,
  input wire logic        m_axis_tready_i,
  input wire logic [15:0] m_axis_tdata_o,
  input wire logic        m_axis_tlast_o
);

  // A stalled unit holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tlast_o))
    else $error("output changed while stalled");

  // With nothing pending the input side is open.
  a_idle_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid_o |-> s_axis_tready_o)
    else $error("input blocked with empty output");

  // More units of the same byte pending: no new byte.
  a_run_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tlast_o |-> !s_axis_tready_o)
    else $error("byte accepted before run ended");

  // A run does not stop before its last unit.
  a_run_continues: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tlast_o && m_axis_tready_i |=> m_axis_tvalid_o)
    else $error("run dropped before its last unit");

endmodule : u8u16_checker

bind utf8_to_utf16_transcoder u8u16_checker u_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tlast_o  (m_axis_tlast_o)
);

`default_nettype wire

// File: test/utf8_to_utf16_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_to_utf16_checker: scoreboard for the UTF-8 to UTF-16 transcoder
// Watches both stream channels, predicts the UTF-16 units for every byte
// taken on the input side and compares each unit leaving the block, in
// order, with the oldest prediction still outstanding.
// ----------------------------------------------------------------------------

module utf8_to_utf16_checker
  import u8u16_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid_i,
  input  logic        s_tready_i,
  input  logic [7:0]  s_tdata_i,
  input  logic        s_tlast_i,
  input  logic        m_tvalid_i,
  input  logic        m_tready_i,
  input  logic [15:0] m_tdata_i,
  input  logic        m_tlast_i,
  output int          fail_count_o,
  output int          pending_o,
  output int          bytes_o,
  output int          units_o,
  output int          pairs_o,
  output int          repl_o
);

  typedef struct packed {
    logic [15:0] unit;
    logic        run_end;
  } utf16_beat_t;

  utf16_beat_t     units_due [$];
  logic [15:0]     step_units [$];

  // Predictor state: bytes of the sequence gathered so far.
  logic [2:0][7:0] held_b   = '0;
  logic [1:0]      held_n   = '0;
  logic [2:0]      want_len = '0;

  function automatic logic [2:0] lead_len(input logic [7:0] b);
    logic [2:0] len;
    casez (b)
      8'b0???????: len = 3'd1;
      8'b110?????: len = 3'd2;
      8'b1110????: len = 3'd3;
      8'b11110???: len = 3'd4;
      default:     len = 3'd0;
    endcase
    return len;
  endfunction

  function automatic void clear_held();
    held_b   = '0;
    held_n   = '0;
    want_len = '0;
  endfunction

  function automatic void emit_unit(input logic [15:0] u);
    if (step_units.size() < MaxUnits) step_units.push_back(u);
  endfunction

  function automatic void emit_cp(input logic [20:0] cp);
    logic [20:0] off;
    if (cp < SuppBase) begin
      emit_unit(cp[15:0]);
    end else begin
      off = cp - SuppBase;
      pairs_o++;
      emit_unit(HiSurrBase + 16'(off[20:10]));
      emit_unit({LoSurrTag, off[9:0]});
    end
  endfunction

  // Decode cnt bytes as one whole string; a lead without enough bytes
  // behind it becomes a replacement and decoding restarts one byte later.
  function automatic void decode_string(input logic [3:0][7:0] bytes, input int cnt);
    int          pos;
    int          len;
    int          k;
    logic [20:0] cp;
    pos = 0;
    while (pos < cnt) begin
      len = int'(lead_len(bytes[pos]));
      if (len == 0 || len > cnt - pos) begin
        emit_unit(ReplUnit);
        repl_o++;
        pos++;
      end else begin
        case (len)
          1:       cp = {13'b0, bytes[pos] & Mask1};
          2:       cp = {13'b0, bytes[pos] & Mask2};
          3:       cp = {13'b0, bytes[pos] & Mask3};
          default: cp = {13'b0, bytes[pos] & Mask4};
        endcase
        for (k = 1; k < len; k++) cp = {cp[14:0], bytes[pos + k][5:0]};
        emit_cp(cp);
        pos += len;
      end
    end
  endfunction

  function automatic void predict_byte(input logic [7:0] b, input logic last);
    logic [3:0][7:0] bytes;
    int              cnt;
    int              i;
    step_units.delete();
    bytes = '0;
    for (i = 0; i < int'(held_n); i++) bytes[i] = held_b[i];
    bytes[held_n] = b;
    cnt = int'(held_n) + 1;
    if (last) begin
      decode_string(bytes, cnt);
      clear_held();
    end else if (held_n == 2'd0) begin
      if (lead_len(b) <= 3'd1) begin
        decode_string(bytes, 1);
      end else begin
        held_b[0] = b;
        held_n    = 2'd1;
        want_len  = lead_len(b);
      end
    end else if (cnt >= int'(want_len)) begin
      decode_string(bytes, cnt);
      clear_held();
    end else begin
      held_b[held_n] = b;
      held_n         = held_n + 2'd1;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    utf16_beat_t due;
    int          i;
    if (!rst_ni) begin
      clear_held();
      units_due.delete();
      fail_count_o = 0;
      pending_o    = 0;
      bytes_o      = 0;
      units_o      = 0;
      pairs_o      = 0;
      repl_o       = 0;
    end else begin
      // Queue the predictions first so a same-edge output still sees the oldest.
      if (s_tvalid_i && s_tready_i) begin
        bytes_o++;
        predict_byte(s_tdata_i, s_tlast_i);
        for (i = 0; i < step_units.size(); i++) begin
          units_due.push_back({step_units[i], 1'(i == step_units.size() - 1)});
        end
      end
      if (m_tvalid_i && m_tready_i) begin
        units_o++;
        if (units_due.size() == 0) begin
          fail_count_o++;
          $display("%0t ns: unit %h (run_end %b) arrived with nothing outstanding",
                   $time, m_tdata_i, m_tlast_i);
        end else begin
          due = units_due.pop_front();
          if (m_tdata_i !== due.unit) begin
            fail_count_o++;
            $display("%0t ns: utf16_unit mismatch, expected %h, actual %h",
                     $time, due.unit, m_tdata_i);
          end
          if (m_tlast_i !== due.run_end) begin
            fail_count_o++;
            $display("%0t ns: run_end mismatch on unit %h, expected %b, actual %b",
                     $time, due.unit, due.run_end, m_tlast_i);
          end
        end
      end
      pending_o = units_due.size();
    end
  end

endmodule

// File: test/tb_utf8_to_utf16_transcoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_utf8_to_utf16_transcoder: stimulus and verdict for the transcoder
// Feeds a short directed byte string, then random UTF-8 strings (mostly
// well formed, some cut short, some noise) in bursts, while the receiver
// stalls on its own pattern including one long hold-off. A checker beside
// the block predicts and compares every unit.
// ----------------------------------------------------------------------------

module tb_utf8_to_utf16_transcoder;

  localparam int RandomBytes = 500;   // stop the random part near this
  localparam int HoldStart   = 400;   // receiver cycle where the long hold-off begins
  localparam int HoldLen     = 200;   // length of that hold-off
  localparam int IdleLimit   = 2000;  // cycles without any transfer before giving up
  localparam int DrainCycles = 16;    // quiet cycles watched after the last unit

  logic        clk           = 1'b0;
  logic        rst_n         = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic [7:0]  s_axis_tdata  = '0;
  logic        s_axis_tlast  = 1'b0;
  logic        m_axis_tready = 1'b0;
  logic        s_axis_tready;
  logic        m_axis_tvalid;
  logic [15:0] m_axis_tdata;
  logic        m_axis_tlast;

  int fail_count;
  int pending;
  int bytes_in;
  int units_out;
  int pairs;
  int repls;

  int bytes_sent  = 0;
  int burst_left  = 0;
  int rx_cycle    = 0;
  int rx_left     = 0;
  int rx_pct      = 0;
  int hold_left   = 0;
  int idle_cycles = 0;

  // Directed string, bit 8 is the final-byte flag:
  // NUL, DEL as a one-byte string, bad lead, 2/3/4-byte forms, the largest
  // four-byte value, an overlong NUL, an encoded surrogate, a four-byte lead
  // cut short by the final byte, and a lone lead carrying the final flag.
  logic [8:0] directed_seq [25] = '{
    9'h000, 9'h17F, 9'h0FF,
    9'h0C2, 9'h0A9,
    9'h0E2, 9'h082, 9'h0AC,
    9'h0F0, 9'h09F, 9'h098, 9'h080,
    9'h0F7, 9'h0BF, 9'h0BF, 9'h0BF,
    9'h0C0, 9'h080,
    9'h0ED, 9'h0A0, 9'h080,
    9'h0F0, 9'h09F, 9'h141,
    9'h1E2
  };

  utf8_to_utf16_transcoder dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .s_axis_tvalid_i(s_axis_tvalid),
    .s_axis_tready_o(s_axis_tready),
    .s_axis_tdata_i (s_axis_tdata),
    .s_axis_tlast_i (s_axis_tlast),
    .m_axis_tvalid_o(m_axis_tvalid),
    .m_axis_tready_i(m_axis_tready),
    .m_axis_tdata_o (m_axis_tdata),
    .m_axis_tlast_o (m_axis_tlast)
  );

  utf8_to_utf16_checker checker_i (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .s_tvalid_i  (s_axis_tvalid),
    .s_tready_i  (s_axis_tready),
    .s_tdata_i   (s_axis_tdata),
    .s_tlast_i   (s_axis_tlast),
    .m_tvalid_i  (m_axis_tvalid),
    .m_tready_i  (m_axis_tready),
    .m_tdata_i   (m_axis_tdata),
    .m_tlast_i   (m_axis_tlast),
    .fail_count_o(fail_count),
    .pending_o   (pending),
    .bytes_o     (bytes_in),
    .units_o     (units_out),
    .pairs_o     (pairs),
    .repl_o      (repls)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Offer one byte and hold it until the transfer. Bursts of random length
  // are separated by random gaps; a zero gap chains two bursts together.
  task automatic send_byte(input logic [7:0] b, input logic last);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      repeat (gap) begin
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    @(negedge clk);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= last;
    do @(posedge clk); while (!s_axis_tready);
    bytes_sent++;
  endtask

  // One random string of up to six sequences. Most strings are well formed
  // with random payload bits (so overlong forms, encoded surrogates and
  // surrogate pairs turn up on their own); some are cut short at the final
  // byte, some break off mid-string, and some are plain noise.
  task automatic send_string();
    int              kind;
    int              nseq;
    int              len;
    int              cut;
    int              s;
    int              i;
    logic            end_mark;
    logic [3:0][7:0] seq;
    kind     = $urandom_range(0, 9);
    nseq     = $urandom_range(1, 6);
    end_mark = (kind == 1) || ($urandom_range(0, 3) != 0);
    if (kind == 0) begin
      for (i = 0; i < nseq; i++) send_byte(8'($urandom), end_mark && i == nseq - 1);
    end else begin
      for (s = 0; s < nseq; s++) begin
        len = $urandom_range(1, 4);
        case (len)
          1:       seq[0] = {1'b0, 7'($urandom)};
          2:       seq[0] = {3'b110, 5'($urandom)};
          3:       seq[0] = {4'b1110, 4'($urandom)};
          default: seq[0] = {5'b11110, 3'($urandom)};
        endcase
        for (i = 1; i < 4; i++) seq[i] = {2'b10, 6'($urandom)};
        // Drop the tail of the last sequence, or of a random one mid-string.
        cut = len;
        if ((kind == 1 && s == nseq - 1) || (kind == 2 && $urandom_range(0, 2) == 0)) begin
          cut = $urandom_range(1, len);
        end
        for (i = 0; i < cut; i++) begin
          send_byte(seq[i], end_mark && s == nseq - 1 && i == cut - 1);
        end
      end
    end
  endtask

  // Receiver: phases of random stall density (including phases with none),
  // plus one long hold-off so the block fills up and backs into its input.
  always @(negedge clk) begin
    if (rst_n) begin
      rx_cycle++;
      if (rx_cycle == HoldStart) hold_left = HoldLen;
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        if (rx_left == 0) begin
          rx_left = $urandom_range(10, 80);
          case ($urandom_range(0, 3))
            0:       rx_pct = 0;
            1:       rx_pct = 25;
            2:       rx_pct = 50;
            default: rx_pct = 85;
          endcase
        end
        rx_left--;
        m_axis_tready <= ($urandom_range(0, 99) >= rx_pct);
      end
    end
  end

  // Watchdog: give up when neither channel moves for too long.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= IdleLimit) begin
          $display("%0t ns: no transfer for %0d cycles, %0d units outstanding",
                   $time, IdleLimit, pending);
          $display("Some tests failed");
          $finish;
        end
      end
    end
  end

  initial begin
    int i;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;

    for (i = 0; i < 25; i++) send_byte(directed_seq[i][7:0], directed_seq[i][8]);

    bytes_sent = 0;
    while (bytes_sent < RandomBytes) send_string();

    @(negedge clk);
    s_axis_tvalid <= 1'b0;

    // Drain: wait for every predicted unit, then watch for strays.
    while (pending != 0) @(negedge clk);
    repeat (DrainCycles) @(negedge clk);

    $display("Covered %0d input bytes and %0d UTF-16 units out,", bytes_in, units_out);
    $display("with %0d surrogate pairs and %0d replacement units.", pairs, repls);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
